>>> rtl/core/pixel16_to_argb32_convert_assert.svh
// ----------------------------------------------------------------------------
// pixel16_to_argb32_convert_assert.svh
// Assertion macros for the top module of the pixel converter.
// ----------------------------------------------------------------------------
`ifndef PIXEL16_TO_ARGB32_CONVERT_ASSERT_SVH
`define PIXEL16_TO_ARGB32_CONVERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define P16A_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p16a assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define P16A_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p16a assertion failed");

`endif

>>> rtl/core/p16a_pkg.sv
// ----------------------------------------------------------------------------
// p16a_pkg
// Types, layout codes and channel widening helpers for the pixel converter.
// ----------------------------------------------------------------------------
package p16a_pkg;

    localparam int LANES = 4;
    localparam int PIX_W = 16;
    localparam int ARGB_W = 32;
    localparam int FMT_W = 5;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [ARGB_W-1:0] t_argb;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGB565   = 5'd0,
        FMT_BGR565   = 5'd1,
        FMT_ARGB1555 = 5'd2,
        FMT_ABGR1555 = 5'd3,
        FMT_RGBA5551 = 5'd4,
        FMT_BGRA5551 = 5'd5,
        FMT_ARGB4444 = 5'd6,
        FMT_ABGR4444 = 5'd7,
        FMT_RGBA4444 = 5'd8,
        FMT_BGRA4444 = 5'd9,
        FMT_XRGB4444 = 5'd10,
        FMT_XBGR4444 = 5'd11,
        FMT_RGBX4444 = 5'd12,
        FMT_BGRX4444 = 5'd13,
        FMT_RGB555   = 5'd14,
        FMT_BGR555   = 5'd15,
        FMT_RG88     = 5'd16,
        FMT_GR88     = 5'd17
    } t_fmt;

    // register index of the format register
    localparam logic REG_FORMAT = 1'b0;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // widen by repeating the top bits
    function automatic logic [7:0] widen1(input logic v);
        return {8{v}};
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

>>> rtl/core/pixel16_to_argb32_convert.sv
// ----------------------------------------------------------------------------
// pixel16_to_argb32_convert
// Converts four 16-bit pixels a beat to ARGB8888 in a configured layout.
// ----------------------------------------------------------------------------
//  channel   handshake                         payload
//  input     start & !busy                     i_pixel_0 .. i_pixel_3
//  result    o_valid (one-cycle strobe)        o_argb_0 .. o_argb_3
//  config    psel & penable & pwrite & pready  paddr, pwdata / prdata
//
//  One beat a clock; busy is never raised. Each result is registered first
//  in the lane decoders, then in the merge register. Synchronous active-low
//  reset clears the strobe pipeline and sets the format to RGB565. The
//  receiver cannot stall; results are not held back.
// ----------------------------------------------------------------------------
module pixel16_to_argb32_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_pixel_0,
    input  logic [15:0] i_pixel_1,
    input  logic [15:0] i_pixel_2,
    input  logic [15:0] i_pixel_3,
    output logic        o_valid,
    output logic [31:0] o_argb_0,
    output logic [31:0] o_argb_1,
    output logic [31:0] o_argb_2,
    output logic [31:0] o_argb_3,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import p16a_pkg::*;

    logic             r_vld;
    logic [FMT_W-1:0] r_fmt;
    logic             cfg_wr;
    t_pix             pix  [LANES];
    t_argb            lane_argb [LANES];
    t_argb            out_argb  [LANES];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_FORMAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB565;
            r_vld <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_fmt <= pwdata[FMT_W-1:0];
            end
            r_vld <= start & ~busy;
        end
    end

    assign prdata = (paddr[2] == REG_FORMAT) ? {{(32-FMT_W){1'b0}}, r_fmt} : 32'd0;

    assign pix[0] = i_pixel_0;
    assign pix[1] = i_pixel_1;
    assign pix[2] = i_pixel_2;
    assign pix[3] = i_pixel_3;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        p16a_lane u_lane (
            .i_clk  (i_clk),
            .i_fmt  (r_fmt),
            .i_pix  (pix[l]),
            .o_argb (lane_argb[l])
        );
    end

    p16a_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld),
        .i_argb  (lane_argb),
        .o_vld   (o_valid),
        .o_argb  (out_argb)
    );

    assign o_argb_0 = out_argb[0];
    assign o_argb_1 = out_argb[1];
    assign o_argb_2 = out_argb[2];
    assign o_argb_3 = out_argb[3];

`include "pixel16_to_argb32_convert_assert.svh"

    `P16A_ASSERT_IMP(a_strobe_from_beat, i_clk, i_rst_n, o_valid, $past(start, 2))
    `P16A_ASSERT_IMP(a_beat_lat2, i_clk, i_rst_n, $past(start, 2) && $past(i_rst_n, 1), o_valid)
    `P16A_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, cfg_wr, r_fmt == $past(pwdata[FMT_W-1:0]))
    `P16A_ASSERT_NXT(a_stage1_feeds_out, i_clk, i_rst_n, r_vld, o_valid)

endmodule

>>> rtl/core/p16a_lane.sv
// ----------------------------------------------------------------------------
// p16a_lane
// One conversion lane: decodes a 16-bit pixel to ARGB8888, registered.
// ----------------------------------------------------------------------------
module p16a_lane (
    input  logic             i_clk,
    input  logic [4:0]       i_fmt,
    input  p16a_pkg::t_pix   i_pix,
    output p16a_pkg::t_argb  o_argb
);
    import p16a_pkg::*;

    logic [7:0] a, r, g, b;
    logic       known;
    t_argb      n_argb;
    t_argb      r_argb;

    always_comb begin
        a     = ALPHA_OPAQUE;
        r     = 8'h00;
        g     = 8'h00;
        b     = 8'h00;
        known = 1'b1;
        unique case (i_fmt)
            FMT_RGB565: begin
                r = widen5(i_pix[15:11]); g = widen6(i_pix[10:5]); b = widen5(i_pix[4:0]);
            end
            FMT_BGR565: begin
                r = widen5(i_pix[4:0]); g = widen6(i_pix[10:5]); b = widen5(i_pix[15:11]);
            end
            FMT_ARGB1555: begin
                a = widen1(i_pix[15]);
                r = widen5(i_pix[14:10]); g = widen5(i_pix[9:5]); b = widen5(i_pix[4:0]);
            end
            FMT_ABGR1555: begin
                a = widen1(i_pix[15]);
                r = widen5(i_pix[4:0]); g = widen5(i_pix[9:5]); b = widen5(i_pix[14:10]);
            end
            FMT_RGBA5551: begin
                a = widen1(i_pix[0]);
                r = widen5(i_pix[15:11]); g = widen5(i_pix[10:6]); b = widen5(i_pix[5:1]);
            end
            FMT_BGRA5551: begin
                a = widen1(i_pix[0]);
                r = widen5(i_pix[5:1]); g = widen5(i_pix[10:6]); b = widen5(i_pix[15:11]);
            end
            FMT_ARGB4444: begin
                a = widen4(i_pix[15:12]);
                r = widen4(i_pix[11:8]); g = widen4(i_pix[7:4]); b = widen4(i_pix[3:0]);
            end
            FMT_ABGR4444: begin
                a = widen4(i_pix[15:12]);
                r = widen4(i_pix[3:0]); g = widen4(i_pix[7:4]); b = widen4(i_pix[11:8]);
            end
            FMT_RGBA4444: begin
                a = widen4(i_pix[3:0]);
                r = widen4(i_pix[15:12]); g = widen4(i_pix[11:8]); b = widen4(i_pix[7:4]);
            end
            FMT_BGRA4444: begin
                a = widen4(i_pix[3:0]);
                r = widen4(i_pix[7:4]); g = widen4(i_pix[11:8]); b = widen4(i_pix[15:12]);
            end
            FMT_XRGB4444: begin
                r = widen4(i_pix[11:8]); g = widen4(i_pix[7:4]); b = widen4(i_pix[3:0]);
            end
            FMT_XBGR4444: begin
                r = widen4(i_pix[3:0]); g = widen4(i_pix[7:4]); b = widen4(i_pix[11:8]);
            end
            FMT_RGBX4444: begin
                r = widen4(i_pix[15:12]); g = widen4(i_pix[11:8]); b = widen4(i_pix[7:4]);
            end
            FMT_BGRX4444: begin
                r = widen4(i_pix[7:4]); g = widen4(i_pix[11:8]); b = widen4(i_pix[15:12]);
            end
            FMT_RGB555: begin
                r = widen5(i_pix[14:10]); g = widen5(i_pix[9:5]); b = widen5(i_pix[4:0]);
            end
            FMT_BGR555: begin
                r = widen5(i_pix[4:0]); g = widen5(i_pix[9:5]); b = widen5(i_pix[14:10]);
            end
            FMT_RG88: begin
                r = i_pix[15:8]; g = i_pix[7:0];
            end
            FMT_GR88: begin
                r = i_pix[7:0]; g = i_pix[15:8];
            end
            default: begin
                known = 1'b0;
            end
        endcase
        // unused layout codes give an all-zero pixel
        n_argb = known ? {a, r, g, b} : '0;
    end

    always_ff @(posedge i_clk) begin
        r_argb <= n_argb;
    end

    assign o_argb = r_argb;

endmodule

>>> rtl/core/p16a_merge.sv
// ----------------------------------------------------------------------------
// p16a_merge
// Output stage: gathers the lane results into one result beat with strobe.
// ----------------------------------------------------------------------------
module p16a_merge (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  p16a_pkg::t_argb  i_argb [p16a_pkg::LANES],
    output logic             o_vld,
    output p16a_pkg::t_argb  o_argb [p16a_pkg::LANES]
);
    import p16a_pkg::*;

    logic  r_vld;
    t_argb r_argb [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // payload only loads on a live beat, so outputs hold between beats
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_argb <= i_argb;
        end
    end

    assign o_vld  = r_vld;
    assign o_argb = r_argb;

endmodule
